// ===== rtl/core/sfur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial firmware update receiver package
// Shared constants and codes: sync bytes, result kinds, run modes, page
// geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package sfur_pkg;

  // Page geometry; the result fields fix a page at 32 words of 8 bytes.
  localparam int PAGE_BYTES  = 256;
  localparam int PAGE_WORDS  = PAGE_BYTES / 8;
  localparam int PWORD_AW    = $clog2(PAGE_WORDS);
  localparam int PIDX_W      = $clog2(PAGE_BYTES) + 1;

  // Frame sync pair.
  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_BYTES     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_BASE_ADDRESS = 1'b1;

  // Result kinds.
  localparam logic [1:0] EV_ACK    = 2'd0;
  localparam logic [1:0] EV_REJECT = 2'd1;
  localparam logic [1:0] EV_PAGE   = 2'd2;
  localparam logic [1:0] EV_DONE   = 2'd3;

  // Run modes.
  localparam logic [1:0] MODE_RECV = 2'd0;
  localparam logic [1:0] MODE_HALT = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  // Flash page word type.
  typedef logic [63:0] flash_word_t;

endpackage

// ===== rtl/core/sfur_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module sfur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/serial_firmware_update_receiver.sv =====
`timescale 1ns / 1ps
// Results: a length frame or a frame with a bad word sum is answered from S_FIN, an
// out-of-order frame from S_ACK; an in-order frame first passes S_PRD and S_PWR
// per stored payload byte; a page flush first sends its 32 flash words (S_FRD, S_FOUT).
// Throughput: one byte per cycle inside a frame; input stalls while a closed frame is
// handled (read-modify-write of each payload byte).
// Reset is synchronous; afterwards a clearing pass fills the page memory with FF.
// ----------------------------------------------------------------------------
// Serial firmware update receiver
// Finds sync pairs, assembles length and data frames, checks the word sum,
// fills a page memory in order and emits acks, rejections, flash page words
// and a completion result.
// ----------------------------------------------------------------------------
module serial_firmware_update_receiver #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_write,
  input  logic [sfur_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // Input byte channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     event_kind,
  output logic [31:0]                    ack_offset,
  output logic [23:0]                    flash_page,
  output logic [4:0]                     word_index,
  output sfur_pkg::flash_word_t          flash_word,
  output logic                           last
);
  import sfur_pkg::*;

  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int FAW = $clog2(FRAME_BYTES);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PWR   = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FOUT  = 4'd6;
  localparam logic [3:0] S_ACK   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]          state;
  logic [1:0]          run_mode;
  logic [31:0]         partition_bytes;
  logic [31:0]         update_base_address;
  logic [CW-1:0]       frame_count;
  logic [31:0]         image_length;
  logic [31:0]         expected_offset;
  logic [7:0]          sync_byte;
  logic [31:0]         hdr;
  logic [31:0]         seq;
  logic [15:0]         sum;
  logic [7:0]          low_byte;
  logic [CW-1:0]       pi;
  logic [PWORD_AW-1:0] wcnt;

  logic                in_acc;
  logic                can_load;
  logic [CW-1:0]       cnt_next;
  logic [CW-1:0]       psize;
  logic                frame_done;
  logic [PIDX_W-1:0]   pos;
  logic                flush_cond;
  logic                complete;
  logic                too_big;
  logic [31:0]         page_addr;

  // Memory ports.
  logic                frame_we;
  logic                frame_re;
  logic [FAW-1:0]      frame_raddr;
  logic [CW-1:0]       frame_rsum;
  logic [7:0]          frame_rdata;
  logic                page_we;
  logic [PWORD_AW-1:0] page_waddr;
  flash_word_t         page_wdata;
  logic                page_re;
  logic [PWORD_AW-1:0] page_raddr;
  flash_word_t         page_rdata;
  flash_word_t         merged;

  // Handshake terms.
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;

  // Frame bookkeeping terms.
  assign cnt_next  = frame_count + CW'(1);
  assign psize     = frame_count - CW'(8);
  assign pos       = {1'b0, seq[PIDX_W-2:0]} + PIDX_W'(pi);
  assign complete  = (expected_offset >= image_length);
  assign too_big   = ({1'b0, hdr} + 33'd8) > {1'b0, partition_bytes};
  assign page_addr = update_base_address + seq;

  assign frame_done =
      ((image_length == 32'd0) && (cnt_next == CW'(6))) ||
      ((cnt_next > CW'(8)) &&
       ({1'b0, image_length} <= (33'(cnt_next - CW'(8)) + {1'b0, expected_offset}))) ||
      (cnt_next >= CW'(FRAME_BYTES));

  assign flush_cond =
      (({1'b0, seq[PIDX_W-2:0]} + PIDX_W'(psize)) >= PIDX_W'(PAGE_BYTES)) ||
      (({1'b0, expected_offset} + 33'(psize)) >= {1'b0, image_length});

  // Frame byte memory: every byte accepted in receive mode is stored at its frame position.
  assign frame_we    = in_acc && (run_mode == MODE_RECV);
  assign frame_re    = (state == S_PRD);
  assign frame_rsum  = CW'(8) + pi;
  assign frame_raddr = frame_rsum[FAW-1:0];

  sfur_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_count[FAW-1:0]),
    .wdata (rx_byte),
    .re    (frame_re),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  // Byte merge into the page word that was just read.
  always_comb begin
    merged = page_rdata;
    merged[{pos[2:0], 3'b000} +: 8] = frame_rdata;
  end

  // Page memory port control.
  always_comb begin
    page_we    = 1'b0;
    page_waddr = wcnt;
    page_wdata = '1;
    page_re    = 1'b0;
    page_raddr = wcnt;
    case (state)
      S_CLEAR: begin
        page_we = 1'b1;
      end
      S_PRD: begin
        page_re    = 1'b1;
        page_raddr = pos[PIDX_W-2:3];
      end
      S_PWR: begin
        page_we    = 1'b1;
        page_waddr = pos[PIDX_W-2:3];
        page_wdata = merged;
      end
      S_FRD: begin
        page_re = 1'b1;
      end
      S_FOUT: begin
        page_we = can_load;
      end
      default: begin
        page_we = 1'b0;
      end
    endcase
  end

  sfur_ram #(
    .WIDTH (64),
    .DEPTH (PAGE_WORDS)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .re    (page_re),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      partition_bytes     <= 32'd131072;
      update_base_address <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PARTITION_BYTES:     partition_bytes     <= cfg_data;
        REG_UPDATE_BASE_ADDRESS: update_base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Header capture and running word sum while a frame arrives.
  always_ff @(posedge clk) begin
    if (frame_we) begin
      if (frame_count == CW'(0)) begin
        sync_byte <= rx_byte;
        sum       <= 16'd0;
      end
      if ((frame_count >= CW'(2)) && (frame_count <= CW'(5))) begin
        hdr[{frame_count[1:0] - 2'd2, 3'b000} +: 8] <= rx_byte;
      end
      if ((frame_count >= CW'(4)) && (frame_count <= CW'(7))) begin
        seq[{frame_count[1:0], 3'b000} +: 8] <= rx_byte;
      end
      if ((frame_count >= CW'(4)) && !frame_count[0]) begin
        low_byte <= rx_byte;
      end
      if ((frame_count >= CW'(5)) && frame_count[0]) begin
        sum <= sum + {rx_byte, low_byte};
      end
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      run_mode        <= MODE_RECV;
      frame_count     <= '0;
      image_length    <= 32'd0;
      expected_offset <= 32'd0;
      wcnt            <= '0;
      pi              <= '0;
      out_valid       <= 1'b0;
    end else begin
      // A result leaves when taken; a new load below overrides this.
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          wcnt <= wcnt + PWORD_AW'(1);
          if (wcnt == PWORD_AW'(PAGE_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (run_mode == MODE_RECV)) begin
            if (frame_count == CW'(0)) begin
              frame_count <= CW'(1);
            end else if (frame_count == CW'(1)) begin
              if ((sync_byte == SYNC_FIRST) && (rx_byte == SYNC_SECOND)) begin
                frame_count <= CW'(2);
              end else begin
                frame_count <= '0;
              end
            end else begin
              frame_count <= cnt_next;
              if (frame_done) begin
                state <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          if (image_length == 32'd0) begin
            // Length frame: accept or reject the image length.
            if (can_load) begin
              out_valid   <= 1'b1;
              ack_offset  <= 32'd0;
              flash_page  <= 24'd0;
              word_index  <= 5'd0;
              flash_word  <= '0;
              last        <= 1'b1;
              frame_count <= '0;
              state       <= S_IDLE;
              if (too_big) begin
                event_kind <= EV_REJECT;
                run_mode   <= MODE_HALT;
              end else begin
                event_kind   <= EV_ACK;
                image_length <= hdr;
              end
            end
          end else if (sum != hdr[15:0]) begin
            // Checksum mismatch: ack the current offset and nothing else.
            if (can_load) begin
              out_valid   <= 1'b1;
              event_kind  <= EV_ACK;
              ack_offset  <= expected_offset;
              flash_page  <= 24'd0;
              word_index  <= 5'd0;
              flash_word  <= '0;
              last        <= 1'b1;
              frame_count <= '0;
              state       <= S_IDLE;
            end
          end else if (seq != expected_offset) begin
            state <= S_ACK;
          end else begin
            pi    <= '0;
            state <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PWR;
        end
        S_PWR: begin
          // Store one payload byte; bytes past the page end are dropped.
          pi <= pi + CW'(1);
          if (((pi + CW'(1)) < psize) && (pos < PIDX_W'(PAGE_BYTES - 1))) begin
            state <= S_PRD;
          end else if (flush_cond) begin
            wcnt  <= '0;
            state <= S_FRD;
          end else begin
            expected_offset <= expected_offset + 32'(psize);
            state           <= S_ACK;
          end
        end
        S_FRD: begin
          state <= S_FOUT;
        end
        S_FOUT: begin
          // Emit one flash word; the memory word is refilled with FF.
          if (can_load) begin
            out_valid  <= 1'b1;
            event_kind <= EV_PAGE;
            ack_offset <= 32'd0;
            flash_page <= page_addr[31:8];
            word_index <= wcnt;
            flash_word <= page_rdata;
            last       <= 1'b0;
            wcnt       <= wcnt + PWORD_AW'(1);
            if (wcnt == PWORD_AW'(PAGE_WORDS - 1)) begin
              expected_offset <= expected_offset + 32'(psize);
              state           <= S_ACK;
            end else begin
              state <= S_FRD;
            end
          end
        end
        S_ACK: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            event_kind  <= EV_ACK;
            ack_offset  <= expected_offset;
            flash_page  <= 24'd0;
            word_index  <= 5'd0;
            flash_word  <= '0;
            last        <= !complete;
            frame_count <= '0;
            state       <= complete ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            event_kind <= EV_DONE;
            ack_offset <= 32'd0;
            flash_page <= 24'd0;
            word_index <= 5'd0;
            flash_word <= '0;
            last       <= 1'b1;
            run_mode   <= MODE_DONE;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The completion result always closes the transactions of its byte.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_DONE) |-> last)
    else $error("completion result without last");

  // Page words are always followed by an ack, so they never close a byte.
  a_page_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_PAGE) |-> !last)
    else $error("page word marked last");

  // A rejection result comes with the halted mode.
  a_reject_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_REJECT) |-> (run_mode == MODE_HALT))
    else $error("rejection without halt");

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (run_mode == MODE_HALT) |=> (run_mode == MODE_HALT))
    else $error("left halted mode");
`endif

endmodule

// ===== bench/serial_firmware_update_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial firmware update receiver testbench
// Streams sync pairs, length frames and data frames into the receiver,
// including bad sync pairs and frames with a broken word sum or an
// out-of-order sequence. A scoreboard mirrors the frame, page and offset
// state. From that state it predicts each ack, rejection, flash word and
// completion transaction, and it compares every result field by field. Idling on
// both channels changes from phase to phase.
// ----------------------------------------------------------------------------
module serial_firmware_update_receiver_tb;
  import sfur_pkg::*;

  localparam int          FRAME_LEN     = 16;
  localparam int          SETTLE_CYCLES = 200;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;

  typedef logic [7:0] frame_t [FRAME_LEN];

  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_SEQ
  } frame_flaw_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ack_offset;
    logic [23:0] flash_page;
    logic [4:0]  word_index;
    flash_word_t flash_word;
    logic        last;
  } update_event_t;

  // Scoreboard: mirrors the receiver state and holds the results still owed.
  class update_scoreboard;
    frame_t        frame_buf;
    int unsigned   frame_len;
    logic [31:0]   image_len;
    logic [31:0]   next_offset;
    logic [31:0]   partition;
    logic [31:0]   base;
    logic [7:0]    page_mem [PAGE_BYTES];
    logic [1:0]    mode;
    update_event_t batch[$];
    update_event_t expected_events[$];
    int unsigned   error_count;

    function new();
      partition   = 32'd131072;
      base        = 32'd0;
      frame_len   = 0;
      image_len   = 32'd0;
      next_offset = 32'd0;
      mode        = MODE_RECV;
      error_count = 0;
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      foreach (page_mem[i]) page_mem[i] = 8'hFF;
    endfunction

    // Wrapping sum of the little-endian words from byte 4 on; an odd tail byte is skipped.
    static function logic [15:0] word_sum(frame_t f, int unsigned n);
      logic [15:0] s;
      int unsigned i;
      s = 16'd0;
      for (i = 0; i < (n - 4) / 2; i++) s = s + {f[5 + 2 * i], f[4 + 2 * i]};
      return s;
    endfunction

    function void configure(logic [31:0] part_bytes, logic [31:0] base_addr);
      partition = part_bytes;
      base      = base_addr;
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    // Prints one line for a mismatch and counts it.
    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
    endtask

    function logic [31:0] get32(int unsigned at);
      return {frame_buf[at + 3], frame_buf[at + 2], frame_buf[at + 1], frame_buf[at]};
    endfunction

    function void add_event(logic [1:0] kind, logic [31:0] off, logic [23:0] pg,
                            logic [4:0] wi, logic [63:0] word);
      update_event_t ev;
      ev.kind       = kind;
      ev.ack_offset = off;
      ev.flash_page = pg;
      ev.word_index = wi;
      ev.flash_word = word;
      ev.last       = 1'b0;
      batch.push_back(ev);
    endfunction

    // A frame has closed: work out its results into the batch.
    function void close_frame();
      logic [31:0] word32;
      logic [31:0] seq;
      logic [31:0] page_addr;
      logic [63:0] fw;
      int unsigned psize, idx, i, w, b;
      batch.delete();
      // Length frame: accept or reject the image size.
      if (image_len == 32'd0) begin
        word32 = get32(2);
        if ({1'b0, word32} + 33'd8 > {1'b0, partition}) begin
          add_event(EV_REJECT, 32'd0, 24'd0, 5'd0, 64'd0);
          mode = MODE_HALT;
        end else begin
          image_len = word32;
          add_event(EV_ACK, 32'd0, 24'd0, 5'd0, 64'd0);
        end
        return;
      end
      // A broken word sum only repeats the current offset.
      if (word_sum(frame_buf, frame_len) != {frame_buf[3], frame_buf[2]}) begin
        add_event(EV_ACK, next_offset, 24'd0, 5'd0, 64'd0);
        return;
      end
      seq = get32(4);
      if (seq == next_offset) begin
        psize = frame_len - 8;
        idx   = seq % PAGE_BYTES;
        for (i = 0; i < psize; i++)
          if (idx + i < PAGE_BYTES) page_mem[idx + i] = frame_buf[8 + i];
        // Flush on a full page or on the end of the image.
        if (idx + psize >= PAGE_BYTES ||
            {1'b0, next_offset} + 33'(psize) >= {1'b0, image_len}) begin
          page_addr = base + seq;
          for (w = 0; w < PAGE_WORDS; w++) begin
            fw = 64'd0;
            for (b = 0; b < 8; b++) fw[8 * b +: 8] = page_mem[w * 8 + b];
            add_event(EV_PAGE, 32'd0, 24'(page_addr / PAGE_BYTES), 5'(w), fw);
          end
          foreach (page_mem[k]) page_mem[k] = 8'hFF;
        end
        next_offset = next_offset + psize;
      end
      add_event(EV_ACK, next_offset, 24'd0, 5'd0, 64'd0);
      if (next_offset >= image_len) begin
        add_event(EV_DONE, 32'd0, 24'd0, 5'd0, 64'd0);
        mode = MODE_DONE;
      end
    endfunction

    // Notes one accepted byte transaction and queues the results it causes.
    function void note_byte(logic [7:0] rx);
      bit closes;
      if (mode != MODE_RECV) return;
      if (frame_len >= FRAME_LEN) frame_len = 0;
      frame_buf[frame_len] = rx;
      frame_len++;
      // The sync pair is checked as a whole and dropped on a mismatch.
      if (frame_len <= 2) begin
        if (frame_len == 2 &&
            (frame_buf[0] != SYNC_FIRST || frame_buf[1] != SYNC_SECOND))
          frame_len = 0;
        return;
      end
      closes = (image_len == 32'd0 && frame_len == 6) ||
               (frame_len > 8 &&
                {1'b0, image_len} <= 33'(frame_len - 8) + {1'b0, next_offset}) ||
               (frame_len >= FRAME_LEN);
      if (!closes) return;
      close_frame();
      frame_len = 0;
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_events.push_back(batch[i]);
    endfunction

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Checks one accepted result transaction against the oldest expectation.
    task check_event(update_event_t got);
      update_event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected result of kind %0d", got.kind));
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", 64'(got.kind), 64'(want.kind));
      compare_field("ack_offset", 64'(got.ack_offset), 64'(want.ack_offset));
      compare_field("flash_page", 64'(got.flash_page), 64'(want.flash_page));
      compare_field("word_index", 64'(got.word_index), 64'(want.word_index));
      compare_field("flash_word", got.flash_word, want.flash_word);
      compare_field("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_write  = 1'b0;
  logic        cfg_index  = REG_PARTITION_BYTES;
  logic [31:0] cfg_data   = 32'd0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte    = 8'd0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  event_kind;
  logic [31:0] ack_offset;
  logic [23:0] flash_page;
  logic [4:0]  word_index;
  flash_word_t flash_word;
  logic        last;

  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  update_scoreboard sb;

  serial_firmware_update_receiver #(
    .FRAME_BYTES(FRAME_LEN)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_kind(event_kind),
    .ack_offset(ack_offset),
    .flash_page(flash_page),
    .word_index(word_index),
    .flash_word(flash_word),
    .last      (last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every accepted result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_event('{event_kind, ack_offset, flash_page, word_index, flash_word, last});
  end

  // Sends one byte transaction, after random idle cycles at the phase rate.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  // Writes both registers; only called while no frame is being received.
  task automatic write_config(input logic [31:0] part_bytes, input logic [31:0] base_addr);
    cfg_write <= 1'b1;
    cfg_index <= REG_PARTITION_BYTES;
    cfg_data  <= part_bytes;
    @(posedge clk);
    cfg_index <= REG_UPDATE_BASE_ADDRESS;
    cfg_data  <= base_addr;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.configure(part_bytes, base_addr);
  endtask

  // Holds the sender until every owed result has come, then lets the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A pair that is not a valid sync pair; half of them start with the first sync byte.
  task automatic send_bad_pair();
    logic [7:0] a, b;
    a = ($urandom_range(0, 1) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    if (a == SYNC_FIRST && b == SYNC_SECOND) b = ~SYNC_SECOND;
    send_byte(a);
    send_byte(b);
  endtask

  task automatic send_length_frame(input logic [31:0] len);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(len[23:16]);
    send_byte(len[31:24]);
  endtask

  // Builds a data frame sized to where the receiver will close it, with an optional flaw.
  task automatic send_data_frame(input frame_flaw_t flaw);
    frame_t      f;
    logic [32:0] remaining;
    logic [31:0] seq;
    logic [15:0] sum;
    int unsigned n, i, fill;
    remaining = {1'b0, sb.image_len} - {1'b0, sb.next_offset};
    n = (remaining < 33'd8) ? 8 + int'(remaining) : FRAME_LEN;
    seq = sb.next_offset;
    if (flaw == FLAW_SEQ)
      seq = ($urandom_range(0, 1) == 0) ? seq + 8 * $urandom_range(1, 40) : $urandom;
    f[0] = SYNC_FIRST;
    f[1] = SYNC_SECOND;
    {f[7], f[6], f[5], f[4]} = seq;
    // Payload is mostly random, sometimes all zeros or all ones.
    fill = $urandom_range(0, 9);
    for (i = 8; i < FRAME_LEN; i++)
      f[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    sum = update_scoreboard::word_sum(f, n);
    if (flaw == FLAW_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
    f[2] = sum[7:0];
    f[3] = sum[15:8];
    for (i = 0; i < n; i++) send_byte(f[i]);
  endtask

  // Main stimulus.
  initial begin
    bit          reject_run;
    logic [31:0] img;
    int          phase, frames, pick;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: bad sync pairs, a zero length at the smallest partition,
    // then either an oversized length or a real image with flawed frames.
    write_config(32'd8, 32'h0000_0000);
    send_byte(8'h00);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_length_frame(32'd0);
    drain_results();
    // A rejection halts the block for good, so only some seeds take that path.
    reject_run = ($urandom_range(0, 4) == 0);
    img = $urandom_range(28, 40);
    if (reject_run) begin
      write_config(32'hFFFF_FFFF, 32'hFFFF_FF00);
      send_length_frame(32'hFFFF_FFF8);
    end else begin
      write_config(img + 32'd8, 32'hFFFF_FF00);
      send_length_frame(img);
      send_data_frame(FLAW_SUM);
      send_data_frame(FLAW_SEQ);
    end

    // Random part in four idling phases, each with its own idle and stall rates and a new config write.
    for (phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_config(32'hFFFF_FFFF, 32'h0000_0000);
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
          write_config($urandom, 32'hFFFF_FF00);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
          write_config($urandom, {24'($urandom), 8'h00});
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
          write_config(img + 32'd8, 32'hFFFF_FF00);
        end
      endcase
      frames = 0;
      while ((phase < 3) ? (frames < 1) : (sb.mode == MODE_RECV && frames < 200)) begin
        if ($urandom_range(0, 3) == 0) send_bad_pair();
        if (sb.mode == MODE_RECV && sb.image_len != 32'd0) begin
          pick = $urandom_range(0, 9);
          send_data_frame((pick == 0) ? FLAW_SUM : (pick == 1) ? FLAW_SEQ : FLAW_NONE);
        end else begin
          repeat (FRAME_LEN) send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 14) == 0) drain_results();
        frames++;
      end
    end

    // Once complete or halted, the block must stay silent.
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    drain_results();

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still owed", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
